// ===== rtl/bclp_pkg.sv =====
// ----------------------------------------------------------------------------
// bclp_pkg
// Shared types and constants of the button click / long press scanner:
// request and result payloads, register map, event codes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bclp_pkg;

  // Field widths
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PinW     = 4;
  localparam int unsigned EvW      = 8;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // Default number of buttons
  localparam int unsigned ButtonCountDef = 4;

  // Register reset values
  localparam logic [ThrW-1:0] DebounceRst   = 16'd50;
  localparam logic [ThrW-1:0] ReleaseGapRst = 16'd150;
  localparam logic [ThrW-1:0] LongPressRst  = 16'd800;
  localparam logic [PinW-1:0] ActLowRst     = 4'hF;

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce   = 8'd0,
    CfgReleaseGap = 8'd1,
    CfgLongPress  = 8'd2,
    CfgActiveLow  = 8'd3
  } cfg_idx_e;

  // Per-button event codes
  typedef enum logic [1:0] {
    EvNone    = 2'd0,
    EvClick   = 2'd1,
    EvLong    = 2'd2,
    EvRelease = 2'd3
  } ev_e;

  // Configuration register contents
  typedef struct packed {
    logic [ThrW-1:0] debounce_ms;
    logic [ThrW-1:0] release_gap_ms;
    logic [ThrW-1:0] long_press_ms;
    logic [PinW-1:0] active_low_mask;
  } cfg_t;

  // Request payload: one scan
  typedef struct packed {
    logic [TimeW-1:0] time_now;
    logic [PinW-1:0]  pin_levels;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [EvW-1:0] button_events;
    logic           any_event;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bclp_cfg.sv =====
// ----------------------------------------------------------------------------
// bclp_cfg
// Configuration register file: debounce, release gap and long press
// thresholds plus the active-low mask. Unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bclp_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [bclp_pkg::CfgIdxW-1:0]  wr_index_i,
  input  wire logic [bclp_pkg::CfgDataW-1:0] wr_data_i,
  output bclp_pkg::cfg_t                     cfg_o
);
  import bclp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write index
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CfgDebounce:   cfg_d.debounce_ms     = wr_data_i[ThrW-1:0];
        CfgReleaseGap: cfg_d.release_gap_ms  = wr_data_i[ThrW-1:0];
        CfgLongPress:  cfg_d.long_press_ms   = wr_data_i[ThrW-1:0];
        CfgActiveLow:  cfg_d.active_low_mask = wr_data_i[PinW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DebounceRst;
      cfg_q.release_gap_ms  <= ReleaseGapRst;
      cfg_q.long_press_ms   <= LongPressRst;
      cfg_q.active_low_mask <= ActLowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/bclp_button.sv =====
// ----------------------------------------------------------------------------
// bclp_button
// Per-button state machine: debounce, click, long press and release
// detection against a wrapping millisecond timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

module bclp_button (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        act_i,
  input  wire logic [bclp_pkg::TimeW-1:0]  now_i,
  input  wire bclp_pkg::cfg_t              cfg_i,
  output bclp_pkg::ev_e                    ev_o
);
  import bclp_pkg::*;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhDown    = 3'd1,
    PhCounter = 3'd2,
    PhPress   = 3'd3,
    PhUp      = 3'd4,
    PhLong    = 3'd5,
    PhRelease = 3'd6
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] stamp_q, stamp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [TimeW-1:0] dt;
  ev_e              ev;

  // Elapsed time, wrapping
  assign dt = now_i - stamp_q;

  // Next phase and event
  always_comb begin
    phase_d = phase_q;
    stamp_d = stamp_q;
    cnt_d   = cnt_q;
    ev      = EvNone;
    unique case (phase_q)
      PhIdle: begin
        if (act_i) begin
          phase_d = PhDown;
          cnt_d   = 2'd0;
          stamp_d = now_i;
        end
      end
      PhDown: begin
        if (!act_i) begin
          phase_d = PhUp;
          stamp_d = now_i;
        end else if (dt > {{(TimeW-ThrW){1'b0}}, cfg_i.debounce_ms}) begin
          phase_d = PhCounter;
        end
      end
      PhCounter: begin
        phase_d = PhPress;
        // Saturate at three
        if (cnt_q != 2'd3) cnt_d = cnt_q + 2'd1;
        if (cnt_d == 2'd1) ev = EvClick;
      end
      PhPress: begin
        if (!act_i) begin
          phase_d = PhUp;
          stamp_d = now_i;
        end else if (dt > {{(TimeW-ThrW){1'b0}}, cfg_i.long_press_ms}) begin
          phase_d = PhLong;
          ev      = EvLong;
        end
      end
      PhUp: begin
        if (act_i) begin
          phase_d = PhDown;
          stamp_d = now_i;
        end else if (dt > {{(TimeW-ThrW){1'b0}}, cfg_i.release_gap_ms}) begin
          phase_d = PhRelease;
          ev      = EvRelease;
        end
      end
      PhLong: begin
        if (!act_i) begin
          phase_d = PhRelease;
          ev      = EvRelease;
        end
      end
      PhRelease: begin
        stamp_d = now_i;
        cnt_d   = 2'd0;
        phase_d = PhIdle;
      end
      default: phase_d = PhIdle;
    endcase
  end

  // Advance state once per scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      stamp_q <= '0;
      cnt_q   <= 2'd0;
    end else if (en_i) begin
      phase_q <= phase_d;
      stamp_q <= stamp_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ev_o = ev;

endmodule

`default_nettype wire

// ===== rtl/button_click_long_press_fsm.sv =====
// ----------------------------------------------------------------------------
// button_click_long_press_fsm
// Button scanner top level: request register, per-button state machines,
// result register and configuration registers.
// ----------------------------------------------------------------------------
// Each request is one scan (millisecond timestamp plus raw pin levels) and
// gives exactly one result with a 2-bit event per button (none, click, long
// press, release) and an any-event flag. While the result side is not stalled,
// a scan is taken every clock cycle: it is captured in the request register,
// then the button machines step while the result register loads, and the
// throughput is one scan per cycle. Only output stall holds the pipe back.
// Configuration writes are always taken (ready is tied high) and should be
// made while no scan is in flight. Buttons past the fourth see a zero pin
// level and never leave idle.
`default_nettype none

module button_click_long_press_fsm #(
  parameter int unsigned BUTTON_COUNT = bclp_pkg::ButtonCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Scan requests
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire bclp_pkg::req_t                in_req_i,
  // Results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output bclp_pkg::res_t                     out_res_o,
  // Configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bclp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bclp_pkg::CfgDataW-1:0] cfg_data_i
);
  import bclp_pkg::*;

  localparam int unsigned SlotCnt = (BUTTON_COUNT < EvW / 2) ? BUTTON_COUNT : EvW / 2;

  cfg_t  cfg;
  logic  req_valid_q, req_valid_d;
  req_t  req_q;
  logic  out_valid_q, out_valid_d;
  res_t  res_q, res_d;
  logic  out_free;
  logic  adv;
  logic  in_acc;
  ev_e   ev [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] ev_hit;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  bclp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = req_valid_q && out_free;
  assign in_stall_o = req_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_acc) req_valid_d = 1'b1;
    else if (adv) req_valid_d = 1'b0;
  end

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_req_i;
  end

  // Per-button state machines
  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_btn
    logic act;
    if (b < PinW) begin : g_pin
      assign act = req_q.pin_levels[b] ^ cfg.active_low_mask[b];
    end else begin : g_nopin
      assign act = 1'b0;
    end

    bclp_button u_btn (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .act_i  (act),
      .now_i  (req_q.time_now),
      .cfg_i  (cfg),
      .ev_o   (ev[b])
    );

    assign ev_hit[b] = (ev[b] != EvNone);
  end

  // Pack events into the result
  always_comb begin
    res_d = '0;
    for (int b = 0; b < SlotCnt; b++) begin
      res_d.button_events[2*b +: 2] = ev[b];
    end
    res_d.any_event = |ev_hit;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // Assertions
  a_stall_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req_valid_q)
    else $error("input stalled with an empty request register");

  a_adv_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("request advanced but no result appeared");

  a_held_req_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && out_valid_o && out_stall_i) |=> req_valid_q)
    else $error("request dropped while the result was stalled");

  a_any_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((BUTTON_COUNT > EvW / 2) ||
                     (out_res_o.any_event == (out_res_o.button_events != '0))))
    else $error("any_event disagrees with button_events");

endmodule

`default_nettype wire

// ===== tb/button_click_long_press_fsm_test.sv =====
// ----------------------------------------------------------------------------
// button_click_long_press_fsm_test
// Self-checking bench for the button scanner: scans are predicted per button
// and every result is compared against the predicted events in order.
// A directed part walks click, long press, multi-tap saturation and timer
// wrap. Random phases then run under several register settings, including
// all-zero and all-max thresholds; all but the last add random gaps on the
// request side and random stall on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_long_press_fsm_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bclp_pkg::*;

  // Per-button machine phases
  typedef enum logic [2:0] {
    BtnIdle    = 3'd0,
    BtnDown    = 3'd1,
    BtnCounter = 3'd2,
    BtnPress   = 3'd3,
    BtnUp      = 3'd4,
    BtnLong    = 3'd5,
    BtnRelease = 3'd6
  } btn_phase_e;

  typedef struct {
    req_t scan;
    bit   drain_first;
  } scan_item_t;

  localparam logic [1:0]         TapMax     = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(CfgActiveLow + 1);
  localparam logic [CfgIdxW-1:0] CfgSpareHi = {CfgIdxW{1'b1}};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  req_t                in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  res_t                out_res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Predictor state and register copy
  cfg_t                cfg_model = '{DebounceRst, ReleaseGapRst, LongPressRst, ActLowRst};
  btn_phase_e          btn_phase [ButtonCountDef];
  logic [TimeW-1:0]    btn_start [ButtonCountDef];
  logic [1:0]          btn_taps  [ButtonCountDef];

  scan_item_t          scan_q[$];
  res_t                events_q[$];
  int                  scans_queued   = 0;
  int                  scans_accepted = 0;
  int                  results_seen   = 0;
  int                  mismatches     = 0;
  int                  regs_written   = 0;
  int                  settings_run   = 1;
  int                  event_tally[4] = '{0, 0, 0, 0};
  bit                  calm           = 1'b0;
  int                  send_gap       = 0;
  int                  hold_left      = 0;

  // Random stimulus state
  logic [TimeW-1:0]    gen_time = '0;
  logic [PinW-1:0]     gen_held = '0;

  button_click_long_press_fsm #(
    .BUTTON_COUNT(ButtonCountDef)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int b = 0; b < ButtonCountDef; b++) begin
      btn_phase[b] = BtnIdle;
      btn_start[b] = '0;
      btn_taps[b]  = '0;
    end
  end

  // Step every button machine on one scan and build the expected events
  function automatic res_t predict_scan(req_t scan);
    res_t             r;
    logic [TimeW-1:0] elapsed;
    logic             act;
    ev_e              ev;
    r = '0;
    for (int b = 0; b < ButtonCountDef; b++) begin
      act     = scan.pin_levels[b] ^ cfg_model.active_low_mask[b];
      elapsed = scan.time_now - btn_start[b];
      ev      = EvNone;
      case (btn_phase[b])
        BtnIdle: begin
          if (act) begin
            btn_phase[b] = BtnDown;
            btn_taps[b]  = '0;
            btn_start[b] = scan.time_now;
          end
        end
        BtnDown: begin
          if (!act) begin
            btn_phase[b] = BtnUp;
            btn_start[b] = scan.time_now;
          end else if (elapsed > cfg_model.debounce_ms) begin
            btn_phase[b] = BtnCounter;
          end
        end
        BtnUp: begin
          if (act) begin
            btn_phase[b] = BtnDown;
            btn_start[b] = scan.time_now;
          end else if (elapsed > cfg_model.release_gap_ms) begin
            btn_phase[b] = BtnRelease;
            ev = EvRelease;
          end
        end
        BtnCounter: begin
          // count taps, saturating; only the first one reports a click
          btn_phase[b] = BtnPress;
          if (btn_taps[b] != TapMax) btn_taps[b] = btn_taps[b] + 1'b1;
          if (btn_taps[b] == 2'd1) ev = EvClick;
        end
        BtnPress: begin
          if (!act) begin
            btn_phase[b] = BtnUp;
            btn_start[b] = scan.time_now;
          end else if (elapsed > cfg_model.long_press_ms) begin
            btn_phase[b] = BtnLong;
            ev = EvLong;
          end
        end
        BtnLong: begin
          if (!act) begin
            btn_phase[b] = BtnRelease;
            ev = EvRelease;
          end
        end
        BtnRelease: begin
          btn_start[b] = scan.time_now;
          btn_taps[b]  = '0;
          btn_phase[b] = BtnIdle;
        end
        default: btn_phase[b] = BtnIdle;
      endcase
      if (ev != EvNone) begin
        r.any_event = 1'b1;
        r.button_events[2*b +: 2] = ev;
        event_tally[ev]++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Request driver: hold a stalled request, advance on acceptance
  always @(posedge clk_i) begin : drive_scans
    scan_item_t pending;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        events_q.push_back(predict_scan(in_req_i));
        scans_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (scan_q.size() != 0 &&
                     !(scan_q[0].drain_first && events_q.size() != 0)) begin
          pending = scan_q.pop_front();
          in_req_i   <= pending.scan;
          in_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest prediction, then pick stall
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (events_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no scan pending", out_res_o));
        end else begin
          want = events_q.pop_front();
          if (out_res_o.button_events !== want.button_events)
            report_mismatch($sformatf("result %0d button_events %h, want %h",
                                      results_seen, out_res_o.button_events,
                                      want.button_events));
          if (out_res_o.any_event !== want.any_event)
            report_mismatch($sformatf("result %0d any_event %b, want %b",
                                      results_seen, out_res_o.any_event,
                                      want.any_event));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 14) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic queue_scan(input logic [TimeW-1:0] stamp, input logic [PinW-1:0] pins,
                            input bit drain_first);
    scan_item_t it;
    it.scan.time_now   = stamp;
    it.scan.pin_levels = pins;
    it.drain_first     = drain_first;
    scan_q.push_back(it);
    scans_queued++;
  endtask

  // Wait until every queued scan is accepted and has its result, plus pipeline margin
  task automatic wait_idle();
    while (scans_accepted != scans_queued || events_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgDebounce:   cfg_model.debounce_ms     = val;
      CfgReleaseGap: cfg_model.release_gap_ms  = val;
      CfgLongPress:  cfg_model.long_press_ms   = val;
      CfgActiveLow:  cfg_model.active_low_mask = val[PinW-1:0];
      default: ;
    endcase
    regs_written++;
  endtask

  // Reprogram all registers once idle; a spare index goes last and must be ignored
  task automatic set_config(input logic [ThrW-1:0] deb, input logic [ThrW-1:0] gap,
                            input logic [ThrW-1:0] lng, input logic [PinW-1:0] mask);
    wait_idle();
    write_reg(CfgDebounce, deb);
    write_reg(CfgReleaseGap, gap);
    write_reg(CfgLongPress, lng);
    write_reg(CfgActiveLow, CfgDataW'(mask));
    write_reg(CfgIdxW'($urandom_range(CfgSpareLo, CfgSpareHi)), CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // Press/release sequences with time steps sized around the thresholds
  task automatic queue_random(input int n, input int drain_at);
    logic [TimeW-1:0] step;
    logic [TimeW-1:0] thr;
    logic [PinW-1:0]  pins;
    int unsigned      pick;
    gen_time = $urandom;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
        0:       thr = TimeW'(cfg_model.debounce_ms);
        1:       thr = TimeW'(cfg_model.release_gap_ms);
        default: thr = TimeW'(cfg_model.long_press_ms);
      endcase
      if (pick < 5)       step = $urandom_range(0, 2);
      else if (pick < 8)  step = thr + $urandom_range(0, 2) - (thr != 0);
      else if (pick == 8) step = $urandom_range(0, 2 * cfg_model.long_press_ms + 4);
      else                step = $urandom;
      gen_time += step;
      for (int b = 0; b < PinW; b++)
        if ($urandom_range(0, 7) == 0) gen_held[b] = ~gen_held[b];
      pins = gen_held ^ cfg_model.active_low_mask;
      if ($urandom_range(0, 19) == 0) pins = PinW'($urandom);
      queue_scan(gen_time, pins, i == drain_at);
    end
  endtask

  initial begin : stimulus
    logic [TimeW-1:0] wrap_base;
    wrap_base = 32'hFFFF_FFFF - 32'd1102;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All buttons at reset settings: debounce edge, click, long press, release
    queue_scan(32'd0,   4'hF, 1'b0);
    queue_scan(32'd10,  4'h0, 1'b0);
    queue_scan(32'd60,  4'h0, 1'b0);
    queue_scan(32'd61,  4'h0, 1'b0);
    queue_scan(32'd62,  4'h0, 1'b0);
    queue_scan(32'd900, 4'h0, 1'b0);
    queue_scan(32'd901, 4'hF, 1'b0);
    queue_scan(32'd902, 4'hF, 1'b0);
    // Button 0 taps four times across the timer wrap; tap count saturates
    queue_scan(wrap_base + 32'd1000, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1100, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1101, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1102, 4'hF, 1'b0);
    queue_scan(wrap_base + 32'd1150, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1210, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1211, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1212, 4'hF, 1'b0);
    queue_scan(wrap_base + 32'd1213, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1300, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1301, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1302, 4'hF, 1'b0);
    queue_scan(wrap_base + 32'd1303, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1400, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1401, 4'hE, 1'b0);
    queue_scan(wrap_base + 32'd1402, 4'hF, 1'b0);
    queue_scan(wrap_base + 32'd1600, 4'hF, 1'b0);
    queue_scan(wrap_base + 32'd1601, 4'hF, 1'b0);

    // Moderate thresholds, with one full drain midway
    set_config(16'd20, 16'd40, 16'd200, 4'($urandom));
    queue_random(300, 150);

    // Lowest settings: every nonzero elapsed time crosses
    set_config(16'd0, 16'd0, 16'd0, 4'h0);
    queue_random(150, -1);

    // Highest settings
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    queue_random(150, 75);

    // Random settings, back-to-back traffic with no idling
    set_config(ThrW'($urandom_range(0, 100)), ThrW'($urandom_range(0, 300)),
               ThrW'($urandom_range(0, 1500)), 4'($urandom));
    calm = 1'b1;
    queue_random(320, -1);

    wait_idle();
    $display("Covered %0d scans over %0d register settings with %0d register writes.",
             scans_accepted, settings_run, regs_written);
    $display("Predicted %0d clicks, %0d long presses, %0d releases; %0d mismatches.",
             event_tally[EvClick], event_tally[EvLong], event_tally[EvRelease],
             mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Timeout with %0d of %0d scans accepted, %0d results pending.",
             scans_accepted, scans_queued, events_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== button_click_long_press_fsm.f =====
rtl/bclp_pkg.sv
rtl/bclp_cfg.sv
rtl/bclp_button.sv
rtl/button_click_long_press_fsm.sv
tb/button_click_long_press_fsm_test.sv
